// ===== rtl/pcs_pkg.sv =====
// shared constants and types for the piecewise constant sampler
`timescale 1ns / 1ps
package pcs_pkg;
	localparam int MAX_BINS_DEF = 1024;
	localparam int W_W = 24;
	localparam int CUM_W = 33;
	localparam int SUM_W = 34;
	localparam int POS_W = 25;
	localparam int IDX_W = 10;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLD_RD,
		ST_BLD_DIV,
		ST_BLD_WR,
		ST_Q_RD,
		ST_Q_CMP,
		ST_Q_LO,
		ST_Q_HI,
		ST_Q_DU,
		ST_Q_POS,
		ST_Q_WRD,
		ST_Q_DEN,
		ST_Q_OUT
	} state_t;

	// control between sequencer and the shared divider
	typedef struct packed {
		logic start;
		logic [5:0] bits;
	} div_ctl_t;
endpackage

// ===== rtl/pcs_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module pcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/pcs_div.sv =====
// bit serial restoring divider: floor(p * 2^bits / s), one quotient bit per cycle
`timescale 1ns / 1ps
module pcs_div #(
	parameter int NW = 60
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pcs_pkg::div_ctl_t ctl,
	input  logic [NW-1:0]   num,
	input  logic [NW-1:0]   den,
	output logic            done,
	output logic [NW-1:0]   quo
);
	logic [NW:0]   r_q;
	logic [NW-1:0] d_q;
	logic [5:0]    cnt_q;
	logic          run_q;
	logic [NW:0]   r2;

	assign r2 = {r_q[NW-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (ctl.start) begin
				done <= 1'b0;
				run_q <= 1'b1;
				cnt_q <= ctl.bits;
				d_q <= den;
				if ({1'b0, num} >= {1'b0, den}) begin
					r_q <= {1'b0, num} - {1'b0, den};
					quo <= NW'(1);
				end else begin
					r_q <= {1'b0, num};
					quo <= '0;
				end
			end else if (run_q) begin
				if (r2 >= {1'b0, d_q}) begin
					r_q <= r2 - {1'b0, d_q};
					quo <= {quo[NW-2:0], 1'b1};
				end else begin
					r_q <= r2;
					quo <= {quo[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				done <= cnt_q == 6'd1;
				if (cnt_q == 6'd1)
					run_q <= 1'b0;
			end else begin
				done <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/piecewise_constant_sampler.sv =====
// top level: weight load, table build and sample query sequencer
`timescale 1ns / 1ps
// A load is stored without raising busy; the last weight starts a build that walks every
// bin through the bit-serial divider. A query scans the cumulative table one entry at a
// time until the first entry above u or the last entry, then runs a 24-bit fraction
// division and one or two 60-bit integer divisions for the position and the density.
// The result appears with done high for one cycle, in the cycle in which busy falls, and
// must be taken then, since the receiver cannot stall. A query before any build returns
// zeros.
module piecewise_constant_sampler #(
	parameter int MAX_BINS = pcs_pkg::MAX_BINS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       op,
	input  logic signed [pcs_pkg::W_W-1:0] weight,
	input  logic                       last,
	input  logic [pcs_pkg::W_W-1:0]    u,
	output logic                       done,
	output logic [pcs_pkg::POS_W-1:0]  position,
	output logic signed [pcs_pkg::W_W-1:0] density,
	output logic [pcs_pkg::IDX_W-1:0]  bin_index
);
	localparam int AW = $clog2(MAX_BINS);
	localparam int CW = $clog2(MAX_BINS + 1);
	localparam int NW = 60;

	pcs_pkg::state_t st_q, st_d;
	logic [CW-1:0] cnt_q;
	logic [pcs_pkg::SUM_W-1:0] sum_q, pre_q;
	logic built_q;
	logic [AW-1:0] i_q;
	logic [pcs_pkg::CUM_W-1:0] lo_q, hi_q;
	logic [32:0] u32_q;
	logic [NW-1:0] du_q;

	logic w_we, c_we;
	logic [AW-1:0] w_addr, c_addr;
	logic [pcs_pkg::W_W-1:0] w_rd;
	logic [pcs_pkg::CUM_W-1:0] c_rd, c_wd;
	pcs_pkg::div_ctl_t dctl;
	logic [NW-1:0] dnum, dden, dquo;
	logic ddone;

	logic [pcs_pkg::W_W-1:0] wmag_in, wmag_rd;
	logic wneg_rd;
	logic accept;
	logic [AW-1:0] last_i;
	logic [pcs_pkg::W_W+CW-1:0] dprod;

	assign accept = start && !busy;
	assign busy = st_q != pcs_pkg::ST_IDLE;
	assign last_i = AW'(cnt_q - CW'(1));
	assign wmag_in = weight[pcs_pkg::W_W-1] ? -weight : weight;
	assign wneg_rd = w_rd[pcs_pkg::W_W-1];
	assign wmag_rd = wneg_rd ? -w_rd : w_rd;
	assign dprod = (pcs_pkg::W_W+CW)'(wmag_rd) * (pcs_pkg::W_W+CW)'(cnt_q);

	pcs_ram #(.WIDTH(pcs_pkg::W_W), .DEPTH(MAX_BINS)) u_wram (
		.clk(clk), .we(w_we), .addr(w_addr), .wdata(weight), .rdata(w_rd)
	);
	pcs_ram #(.WIDTH(pcs_pkg::CUM_W), .DEPTH(MAX_BINS)) u_cram (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd)
	);
	pcs_div #(.NW(NW)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	logic reload, store_ok;
	assign reload = built_q;
	assign store_ok = reload || (cnt_q < CW'(MAX_BINS));

	always_comb begin
		st_d = st_q;
		w_we = 1'b0;
		w_addr = i_q;
		c_we = 1'b0;
		c_addr = i_q;
		c_wd = dquo[pcs_pkg::CUM_W-1:0];
		dctl = '0;
		dnum = '0;
		dden = '0;
		case (st_q)
			pcs_pkg::ST_IDLE: begin
				if (accept && op == pcs_pkg::OP_LOAD) begin
					w_we = store_ok;
					w_addr = reload ? '0 : AW'(cnt_q);
				end
				if (accept && op == pcs_pkg::OP_LOAD && last)
					st_d = pcs_pkg::ST_BLD_RD;
				else if (accept && op == pcs_pkg::OP_QUERY)
					st_d = (built_q && cnt_q != '0) ? pcs_pkg::ST_Q_RD : pcs_pkg::ST_Q_OUT;
			end
			pcs_pkg::ST_BLD_RD: begin
				if (cnt_q == '0)
					st_d = pcs_pkg::ST_IDLE;
				else
					st_d = pcs_pkg::ST_BLD_DIV;
			end
			pcs_pkg::ST_BLD_DIV: begin
				// w_rd valid now; start the divider
				dctl.start = 1'b1;
				dctl.bits = 6'd32;
				if (sum_q == '0) begin
					dnum = NW'({1'b0, i_q} + (AW+1)'(1));
					dden = NW'(cnt_q);
				end else begin
					dnum = NW'(pre_q + pcs_pkg::SUM_W'(wmag_rd));
					dden = NW'(sum_q);
				end
				st_d = pcs_pkg::ST_BLD_WR;
			end
			pcs_pkg::ST_BLD_WR: begin
				if (ddone) begin
					c_we = 1'b1;
					if (sum_q != '0 && i_q == last_i)
						c_wd = pcs_pkg::CUM_W'(64'd1 << 32);
					st_d = (i_q == last_i) ? pcs_pkg::ST_IDLE : pcs_pkg::ST_BLD_RD;
				end
			end
			pcs_pkg::ST_Q_RD: st_d = pcs_pkg::ST_Q_CMP;
			pcs_pkg::ST_Q_CMP: begin
				if (c_rd > u32_q || i_q == last_i)
					st_d = pcs_pkg::ST_Q_HI;
				else
					st_d = pcs_pkg::ST_Q_RD;
			end
			pcs_pkg::ST_Q_HI: begin
				// hi_q latched; fetch the lower bound and the weight
				c_addr = i_q - AW'(1);
				st_d = pcs_pkg::ST_Q_LO;
			end
			pcs_pkg::ST_Q_LO: begin
				c_addr = i_q - AW'(1);
				st_d = pcs_pkg::ST_Q_DU;
			end
			pcs_pkg::ST_Q_DU: begin
				if (hi_q > lo_q && u32_q >= lo_q) begin
					dctl.start = 1'b1;
					dctl.bits = 6'd24;
					dnum = NW'((u32_q - lo_q) > (hi_q - lo_q) ? (hi_q - lo_q) : (u32_q - lo_q));
					dden = NW'(hi_q - lo_q);
					st_d = pcs_pkg::ST_Q_POS;
				end else begin
					st_d = pcs_pkg::ST_Q_WRD;
				end
			end
			pcs_pkg::ST_Q_POS: if (ddone) st_d = pcs_pkg::ST_Q_WRD;
			// position = floor((idx*2^24 + du)/n) in the local integer divider
			pcs_pkg::ST_Q_WRD: st_d = pcs_pkg::ST_Q_DEN;
			pcs_pkg::ST_Q_DEN: st_d = pcs_pkg::ST_Q_OUT;
			pcs_pkg::ST_Q_OUT: st_d = pcs_pkg::ST_IDLE;
			default: st_d = pcs_pkg::ST_IDLE;
		endcase
	end

	// integer divisions done by a second serial pass in a small local loop
	logic [NW-1:0] ir_q, iq_q, iden_q, inum_q;
	logic [6:0] ic_q;
	logic irun_q, neg_q;
	logic [1:0] iph_q;
	logic [NW:0] ir2;
	logic qbit;
	logic [NW-1:0] iq_nx;
	assign ir2 = {ir_q, inum_q[NW-1]};
	assign qbit = ir2 >= {1'b0, iden_q};
	assign iq_nx = {iq_q[NW-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pcs_pkg::ST_IDLE;
			cnt_q <= '0;
			sum_q <= '0;
			built_q <= 1'b0;
			done <= 1'b0;
			irun_q <= 1'b0;
			iph_q <= '0;
		end else begin
			done <= st_q == pcs_pkg::ST_Q_OUT;
			st_q <= irun_q ? st_q : st_d;
			case (st_q)
				pcs_pkg::ST_IDLE: begin
					i_q <= '0;
					pre_q <= '0;
					u32_q <= {1'b0, u, 8'd0};
					if (accept && op == pcs_pkg::OP_LOAD) begin
						if (reload) begin
							built_q <= 1'b0;
							cnt_q <= CW'(1);
							sum_q <= pcs_pkg::SUM_W'(wmag_in);
						end else if (store_ok) begin
							cnt_q <= cnt_q + CW'(1);
							sum_q <= sum_q + pcs_pkg::SUM_W'(wmag_in);
						end
						if (last && !(reload ? 1'b0 : cnt_q == '0 && !store_ok))
							built_q <= 1'b1;
					end
				end
				pcs_pkg::ST_BLD_DIV: pre_q <= pre_q + pcs_pkg::SUM_W'(wmag_rd);
				pcs_pkg::ST_BLD_WR: if (ddone) i_q <= i_q + AW'(1);
				pcs_pkg::ST_Q_CMP: begin
					hi_q <= c_rd;
					if (!(c_rd > u32_q || i_q == last_i))
						i_q <= i_q + AW'(1);
				end
				pcs_pkg::ST_Q_LO: begin
					// lower bound read was issued in ST_Q_HI
					lo_q <= (i_q != '0) ? c_rd : '0;
					du_q <= '0;
				end
				pcs_pkg::ST_Q_POS: if (ddone) du_q <= dquo;
				pcs_pkg::ST_Q_WRD: begin
					// start integer divide for position
					irun_q <= 1'b1;
					iph_q <= 2'd0;
					inum_q <= NW'({i_q, 24'd0}) + du_q;
					iden_q <= NW'(cnt_q);
					ir_q <= '0;
					iq_q <= '0;
					ic_q <= 7'(NW);
				end
				pcs_pkg::ST_Q_OUT: begin
					if (!(built_q && cnt_q != '0)) begin
						position <= '0;
						density <= '0;
						bin_index <= '0;
					end
				end
				default: ;
			endcase
			if (irun_q) begin
				if (ic_q != 7'd1) begin
					ir_q <= qbit ? NW'(ir2 - {1'b0, iden_q}) : NW'(ir2);
					iq_q <= iq_nx;
					inum_q <= {inum_q[NW-2:0], 1'b0};
					ic_q <= ic_q - 7'd1;
				end else if (iph_q == 2'd0) begin
					position <= pcs_pkg::POS_W'(iq_nx);
					bin_index <= pcs_pkg::IDX_W'(i_q);
					if (sum_q == '0) begin
						density <= '0;
						irun_q <= 1'b0;
					end else begin
						iph_q <= 2'd1;
						neg_q <= wneg_rd;
						inum_q <= NW'({dprod, 16'd0});
						iden_q <= NW'(sum_q);
						ir_q <= '0;
						iq_q <= '0;
						ic_q <= 7'(NW);
					end
				end else begin
					irun_q <= 1'b0;
					if (neg_q)
						density <= (iq_nx > NW'(24'h800000))
							? pcs_pkg::W_W'(24'h800000)
							: -pcs_pkg::W_W'(iq_nx);
					else
						density <= (iq_nx > NW'(24'h7fffff))
							? pcs_pkg::W_W'(24'h7fffff)
							: pcs_pkg::W_W'(iq_nx);
				end
			end
		end
	end
endmodule

// ===== verif/pcs_checker.sv =====
// checker for the piecewise constant sampler: predicts each query result and compares
`timescale 1ns / 1ps
module pcs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          op,
	input  logic [pcs_pkg::W_W-1:0]       weight,
	input  logic                          last,
	input  logic [pcs_pkg::W_W-1:0]       u,
	input  logic                          done,
	input  logic [pcs_pkg::POS_W-1:0]     position,
	input  logic [pcs_pkg::W_W-1:0]       density,
	input  logic [pcs_pkg::IDX_W-1:0]     bin_index,
	output int                            errors,
	output int                            pending,
	output int                            n_loads,
	output int                            n_queries,
	output int                            n_builds
);
	localparam int NBINS = pcs_pkg::MAX_BINS_DEF;
	localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

	typedef struct packed {
		logic [pcs_pkg::POS_W-1:0] pos;
		logic [pcs_pkg::W_W-1:0]   dens;
		logic [pcs_pkg::IDX_W-1:0] idx;
	} sample_t;

	logic [pcs_pkg::W_W-1:0] wt_mem [NBINS];
	logic [63:0]    cum_mem [NBINS];
	int unsigned    nbins;
	logic [63:0]    mag_total;
	bit             table_ok;
	sample_t        samples_due [$];
	int             shown;

	function automatic logic [63:0] magnitude(logic [pcs_pkg::W_W-1:0] raw);
		return raw[pcs_pkg::W_W-1] ? 64'h100_0000 - 64'(raw) : 64'(raw);
	endfunction

	// floor(p * 2^bits / s), p <= s
	function automatic logic [63:0] scaled_ratio(logic [63:0] p, logic [63:0] s, int bits);
		logic [127:0] t;
		t = 128'(p) << bits;
		return 64'(t / 128'(s));
	endfunction

	function automatic void build_table();
		logic [63:0] run;
		run = 0;
		if (nbins == 0)
			return;
		for (int i = 0; i < nbins; i++) begin
			if (mag_total == 0)
				cum_mem[i] = scaled_ratio(64'(i + 1), 64'(nbins), 32);
			else begin
				run += magnitude(wt_mem[i]);
				cum_mem[i] = (i == nbins - 1) ? ONE_Q32 : scaled_ratio(run, mag_total, 32);
			end
		end
		table_ok = 1;
	endfunction

	function automatic sample_t draw_sample(logic [pcs_pkg::W_W-1:0] uq);
		sample_t r;
		int unsigned k;
		logic [63:0] uu, lo, hi, num, du, d;
		r = '0;
		if (!table_ok || nbins == 0)
			return r;
		uu = 64'(uq) << 8;
		k = 0;
		while (k < nbins && cum_mem[k] <= uu)
			k++;
		if (k > nbins - 1)
			k = nbins - 1;
		lo = (k == 0) ? 64'd0 : cum_mem[k-1];
		hi = cum_mem[k];
		du = 0;
		if (hi > lo && uu >= lo) begin
			num = uu - lo;
			if (num > hi - lo)
				num = hi - lo;
			du = scaled_ratio(num, hi - lo, 24);
		end
		r.pos = pcs_pkg::POS_W'(((64'(k) << 24) + du) / 64'(nbins));
		if (mag_total != 0) begin
			d = ((magnitude(wt_mem[k]) * 64'(nbins)) << 16) / mag_total;
			if (wt_mem[k][pcs_pkg::W_W-1]) begin
				if (d > 64'h80_0000)
					d = 64'h80_0000;
				r.dens = pcs_pkg::W_W'(64'h100_0000 - d);
			end else begin
				if (d > 64'h7F_FFFF)
					d = 64'h7F_FFFF;
				r.dens = pcs_pkg::W_W'(d);
			end
		end
		r.idx = pcs_pkg::IDX_W'(k);
		return r;
	endfunction

	assign pending = samples_due.size();

	always @(posedge clk or negedge arst_n) begin
		sample_t got, want;
		if (!arst_n) begin
			nbins = 0;
			mag_total = 0;
			table_ok = 0;
			samples_due.delete();
		end else begin
			if (start && !busy) begin
				if (op == pcs_pkg::OP_LOAD) begin
					n_loads++;
					// a new load after a build starts from scratch
					if (table_ok) begin
						nbins = 0;
						mag_total = 0;
						table_ok = 0;
					end
					if (nbins < NBINS) begin
						wt_mem[nbins] = weight;
						mag_total += magnitude(weight);
						nbins++;
					end
					if (last) begin
						build_table();
						n_builds++;
					end
				end else begin
					n_queries++;
					samples_due.push_back(draw_sample(u));
				end
			end
			if (done) begin
				got = '{pos: position, dens: density, idx: bin_index};
				if (samples_due.size() == 0) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("unexpected result: pos %h dens %h idx %0d",
							position, density, bin_index);
					end
				end else begin
					want = samples_due.pop_front();
					if (got != want) begin
						errors++;
						if (shown < 10) begin
							shown++;
							$display("mismatch: pos exp %h got %h, dens exp %h got %h,",
								want.pos, got.pos, want.dens, got.dens);
							$display("  idx exp %0d got %0d", want.idx, got.idx);
						end
					end
				end
			end
		end
	end
endmodule

// ===== verif/tb_piecewise_constant_sampler.sv =====
// testbench top for the piecewise constant sampler: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_piecewise_constant_sampler;
	localparam int IDLE_LIMIT = 400000;
	localparam int N_ITEMS = 1150;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic op = pcs_pkg::OP_LOAD;
	logic [pcs_pkg::W_W-1:0] weight = '0;
	logic last = 0;
	logic [pcs_pkg::W_W-1:0] u = '0;
	logic busy, done;
	logic [pcs_pkg::POS_W-1:0] position;
	logic [pcs_pkg::W_W-1:0] density;
	logic [pcs_pkg::IDX_W-1:0] bin_index;
	int errors, pending, n_loads, n_queries, n_builds;
	int idle_cycles = 0;
	int sent = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	piecewise_constant_sampler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.weight(weight), .last(last), .u(u), .done(done), .position(position),
		.density(density), .bin_index(bin_index)
	);

	pcs_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.weight(weight), .last(last), .u(u), .done(done), .position(position),
		.density(density), .bin_index(bin_index), .errors(errors),
		.pending(pending), .n_loads(n_loads), .n_queries(n_queries),
		.n_builds(n_builds)
	);

	// one transfer; start stays high when the next item follows with no gap
	task automatic send(logic o, logic [pcs_pkg::W_W-1:0] w, logic l,
			logic [pcs_pkg::W_W-1:0] q);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		op <= o;
		weight <= w;
		last <= l;
		u <= q;
		do @(negedge clk); while (busy);
		@(posedge clk);
		sent++;
	endtask

	task automatic load_w(logic [pcs_pkg::W_W-1:0] w, logic l);
		send(pcs_pkg::OP_LOAD, w, l, pcs_pkg::W_W'($urandom()));
	endtask

	task automatic query(logic [pcs_pkg::W_W-1:0] q);
		send(pcs_pkg::OP_QUERY, pcs_pkg::W_W'($urandom()), 1'($urandom_range(0, 1)), q);
	endtask

	function automatic logic [pcs_pkg::W_W-1:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2: return '0;
			3: return pcs_pkg::W_W'($urandom_range(0, 255)) - 24'd128;
			default: return pcs_pkg::W_W'($urandom());
		endcase
	endfunction

	function automatic logic [pcs_pkg::W_W-1:0] rand_u();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 24'hFF_FFFF;
			default: return pcs_pkg::W_W'($urandom());
		endcase
	endfunction

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int nb, nq;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: queries before any build
		query('0);
		query(24'hFF_FFFF);
		// extremes of weight, then queries at the ends and middle
		load_w(24'h7F_FFFF, 0);
		load_w(24'h80_0000, 0);
		load_w('0, 0);
		load_w(24'h00_0001, 1);
		query('0);
		query(24'hFF_FFFF);
		query(24'h80_0000);
		// all-zero weights give a uniform table
		load_w('0, 0);
		load_w('0, 0);
		load_w('0, 1);
		query(24'h55_5555);
		query(24'hFF_FFFF);
		// single bin
		load_w(24'hFF_FFFF, 1);
		query(24'h12_3456);
		// query in the middle of a load
		load_w(24'h00_1000, 0);
		query(24'h40_0000);
		load_w(24'hFF_F000, 1);
		query(24'h7F_FFFF);

		// overflow: more weights than bins, last mark on a dropped one, saturating density
		for (int i = 0; i < pcs_pkg::MAX_BINS_DEF + 6; i++)
			load_w(i == 3 ? 24'h7F_FFFF : i == 700 ? 24'h80_0000 :
				($urandom_range(0, 7) == 0 ? pcs_pkg::W_W'($urandom() & 32'hFF) : '0),
				i == pcs_pkg::MAX_BINS_DEF + 5);
		repeat (6) query(rand_u());

		// random loads of mostly small size followed by queries
		while (sent < N_ITEMS) begin
			nb = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			for (int i = 0; i < nb; i++) begin
				if ($urandom_range(0, 15) == 0)
					query(rand_u());
				load_w(($urandom_range(0, 7) == 0) ? '0 : rand_weight(), i == nb - 1);
			end
			nq = $urandom_range(1, 8);
			for (int i = 0; i < nq; i++)
				query(rand_u());
		end
		start <= 0;

		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d weight transfers, %0d queries and %0d table builds,",
			n_loads, n_queries, n_builds);
		$display("including empty-table queries, zero sums, one bin and load overflow");
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
